@@ sv/sparc_muldiv_emulation_defines.svh @@
// Assertion macros for the multiply/divide execution block.
`ifndef SPARC_MULDIV_EMULATION_DEFINES_SVH
`define SPARC_MULDIV_EMULATION_DEFINES_SVH

// Implication checked at every edge outside reset.
`define SMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define SMD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/smd_pkg.sv @@
// Shared types and constants for the multiply/divide execution block.
package smd_pkg;

  localparam int unsigned SMD_CELLS = 32;

  localparam logic [31:0] SMD_OP_MASK  = 32'hC150_0000;
  localparam logic [31:0] SMD_OP_MATCH = 32'h8050_0000;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_UNIMP  = 2'd1,
    ST_DIVZ   = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  rd;
    logic [31:0] y_in;
    logic        is_div;
    logic        neg;
    logic        cc;
    logic [63:0] prod;
  } meta_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dvd;
    logic [31:0] dvs;
    logic [31:0] quo;
  } div_t;

endpackage

@@ sv/smd_front.sv @@
// Decode, operand magnitudes and the magnitude multiply, two registered stages.
module smd_front import smd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] instr_word,
  input  logic [31:0] rs1_value,
  input  logic [31:0] rs2_value,
  input  logic [31:0] y_in,
  output logic        out_valid,
  output meta_t       out_meta,
  output div_t        out_div
);

  logic [31:0] op2;
  logic        is_div, is_sgn, na, nb;
  status_t     st;

  logic        v1_r, v1_nxt;
  meta_t       m1_r, m1_nxt;
  logic [31:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic        v2_r;
  meta_t       m2_r, m2_nxt;
  div_t        d2_r;

  always_comb begin
    op2    = instr_word[13] ? {{19{instr_word[12]}}, instr_word[12:0]} : rs2_value;
    is_div = instr_word[21];
    is_sgn = instr_word[19];
    na     = is_sgn & rs1_value[31];
    nb     = is_sgn & op2[31];
    if ((instr_word & SMD_OP_MASK) != SMD_OP_MATCH) begin
      st = ST_UNIMP;
    end else if (is_div) begin
      if (y_in != '0 && y_in != '1) begin
        st = ST_UNIMP;
      end else if (op2 == '0) begin
        st = ST_DIVZ;
      end else if (is_sgn) begin
        st = (y_in != {32{rs1_value[31]}}) ? ST_UNIMP : ST_DONE;
      end else begin
        st = (y_in != '0) ? ST_UNIMP : ST_DONE;
      end
    end else begin
      st = ST_DONE;
    end
    v1_nxt        = in_valid;
    m1_nxt.status = st;
    m1_nxt.rd     = instr_word[29:25];
    m1_nxt.y_in   = y_in;
    m1_nxt.is_div = is_div;
    m1_nxt.neg    = na ^ nb;
    m1_nxt.cc     = instr_word[23];
    m1_nxt.prod   = '0;
    ma_nxt        = na ? (32'd0 - rs1_value) : rs1_value;
    mb_nxt        = nb ? (32'd0 - op2) : op2;
  end

  always_comb begin
    m2_nxt      = m1_r;
    m2_nxt.prod = {32'd0, ma_r} * {32'd0, mb_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r      <= m1_nxt;
      ma_r      <= ma_nxt;
      mb_r      <= mb_nxt;
      m2_r      <= m2_nxt;
      d2_r.rem  <= '0;
      d2_r.dvd  <= ma_r;
      d2_r.dvs  <= mb_r;
      d2_r.quo  <= '0;
    end
  end

  assign out_valid = v2_r;
  assign out_meta  = m2_r;
  assign out_div   = d2_r;

endmodule

@@ sv/smd_cell.sv @@
// One restoring-division cell: develops one quotient bit and hands on.
module smd_cell import smd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_valid,
  input  meta_t in_meta,
  input  div_t  in_div,
  output logic  out_valid,
  output meta_t out_meta,
  output div_t  out_div
);

  logic [32:0] trial;
  logic        ge;
  div_t        d_nxt;
  logic        v_r;
  meta_t       m_r;
  div_t        d_r;

  always_comb begin
    trial       = {in_div.rem, in_div.dvd[31]};
    ge          = trial >= {1'b0, in_div.dvs};
    d_nxt       = in_div;
    d_nxt.rem   = ge ? 32'(trial - {1'b0, in_div.dvs}) : trial[31:0];
    d_nxt.dvd   = {in_div.dvd[30:0], 1'b0};
    d_nxt.quo   = {in_div.quo[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r <= in_meta;
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_meta  = m_r;
  assign out_div   = d_r;

endmodule

@@ sv/sparc_muldiv_emulation.sv @@
// Top level: SPARC V8 multiply/divide execution pipeline.
// Takes one instruction per cycle and returns one result per instruction, in order,
// through a pipeline of two front stages (decode, 32x32 magnitude
// multiply), a chain of 32 division cells that each produce one quotient bit,
// and one output stage that applies signs and flags. The whole pipeline holds
// while a finished result waits on out_tready.
`include "sparc_muldiv_emulation_defines.svh"
module sparc_muldiv_emulation import smd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // instr_word[31:0], rs1_value[63:32], rs2_value[95:64], y_in[127:96]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], dest_index[6:2], dest_value[38:7], y_out[70:39], y_written[71],
  // set_cc[72], cc_negative[73], cc_zero[74], zero pad[79:75]
  output logic [79:0]  out_tdata
);

  logic  adv;
  logic  c_valid [0:SMD_CELLS];
  meta_t c_meta  [0:SMD_CELLS];
  div_t  c_div   [0:SMD_CELLS];

  logic        ov_r;
  logic [1:0]  st_r, st_nxt;
  logic [4:0]  rd_r, rd_nxt;
  logic [31:0] dv_r, dv_nxt, yo_r, yo_nxt;
  logic        yw_r, yw_nxt, cc_r, cc_nxt, n_r, n_nxt, z_r, z_nxt;
  logic [63:0] sprod;
  logic [31:0] squo;
  meta_t       fm;

  assign adv       = !ov_r || out_tready;
  assign in_tready = adv;

  smd_front u_front (
    .clk, .rst_n, .adv,
    .in_valid   (in_tvalid),
    .instr_word (in_tdata[31:0]),
    .rs1_value  (in_tdata[63:32]),
    .rs2_value  (in_tdata[95:64]),
    .y_in       (in_tdata[127:96]),
    .out_valid  (c_valid[0]),
    .out_meta   (c_meta[0]),
    .out_div    (c_div[0])
  );

  for (genvar i = 0; i < SMD_CELLS; i++) begin : g_cell
    smd_cell u_cell (
      .clk, .rst_n, .adv,
      .in_valid  (c_valid[i]),
      .in_meta   (c_meta[i]),
      .in_div    (c_div[i]),
      .out_valid (c_valid[i+1]),
      .out_meta  (c_meta[i+1]),
      .out_div   (c_div[i+1])
    );
  end

  always_comb begin
    fm     = c_meta[SMD_CELLS];
    sprod  = fm.neg ? (64'd0 - fm.prod) : fm.prod;
    squo   = fm.neg ? (32'd0 - c_div[SMD_CELLS].quo) : c_div[SMD_CELLS].quo;
    st_nxt = fm.status;
    rd_nxt = fm.rd;
    if (fm.status != ST_DONE) begin
      dv_nxt = '0;
      yo_nxt = fm.y_in;
      yw_nxt = 1'b0;
    end else if (fm.is_div) begin
      dv_nxt = squo;
      yo_nxt = fm.y_in;
      yw_nxt = 1'b0;
    end else begin
      dv_nxt = sprod[31:0];
      yo_nxt = sprod[63:32];
      yw_nxt = 1'b1;
    end
    cc_nxt = (fm.status == ST_DONE) && fm.cc;
    n_nxt  = cc_nxt & dv_nxt[31];
    z_nxt  = cc_nxt & (dv_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= c_valid[SMD_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
      rd_r <= rd_nxt;
      dv_r <= dv_nxt;
      yo_r <= yo_nxt;
      yw_r <= yw_nxt;
      cc_r <= cc_nxt;
      n_r  <= n_nxt;
      z_r  <= z_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, z_r, n_r, cc_r, yw_r, yo_r, dv_r, rd_r, st_r};

  `SMD_ASSERT_NEVER(a_yw_done, out_tvalid && yw_r && st_r != ST_DONE, "Y written on failed op")
  `SMD_ASSERT_NEVER(a_cc_done, out_tvalid && cc_r && st_r != ST_DONE, "cc set on failed op")
  `SMD_ASSERT_IMPL(a_fail_zero, out_tvalid && st_r != ST_DONE, dv_r == '0 && !n_r && !z_r, "fail payload")

endmodule

@@ tb/sv/smd_checker.sv @@
// Checker for the multiply/divide block: predicts each result and compares it.
module smd_checker import smd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [79:0]  out_tdata,
  output int           fail_count,
  output int           pending,
  output int           result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       cc_zero;
    logic       cc_negative;
    logic       set_cc;
    logic       y_written;
    logic [31:0] y_out;
    logic [31:0] dest_value;
    logic [4:0]  dest_index;
    status_t     status;
  } exec_result_t;

  exec_result_t expected_results[$];

  function automatic exec_result_t execute_instr(logic [127:0] d);
    logic [31:0] iw, a, r2, y, b, ma, mb, q, ext;
    logic [63:0] p;
    exec_result_t r;
    iw = d[31:0]; a = d[63:32]; r2 = d[95:64]; y = d[127:96];
    b = iw[13] ? {{19{iw[12]}}, iw[12:0]} : r2;
    r = '0;
    r.status = ST_DONE;
    r.dest_index = iw[29:25];
    r.y_out = y;
    if ((iw & SMD_OP_MASK) != SMD_OP_MATCH) begin
      r.status = ST_UNIMP;
    end else if (iw[21]) begin
      ext = {32{a[31]}};
      if (y != 32'h0 && y != 32'hFFFF_FFFF) r.status = ST_UNIMP;
      else if (b == 32'h0) r.status = ST_DIVZ;
      else if (iw[19]) begin
        if (y != ext) r.status = ST_UNIMP;
        else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          r.dest_value = (a[31] != b[31]) ? -q : q;
        end
      end else begin
        if (y != 32'h0) r.status = ST_UNIMP;
        else r.dest_value = a / b;
      end
    end else begin
      if (iw[19]) p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
      else p = {32'h0, a} * {32'h0, b};
      r.dest_value = p[31:0];
      r.y_out = p[63:32];
      r.y_written = 1'b1;
    end
    if (r.status == ST_DONE && iw[23]) begin
      r.set_cc = 1'b1;
      r.cc_negative = r.dest_value[31];
      r.cc_zero = (r.dest_value == 32'h0);
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    exec_result_t got, exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(execute_instr(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[74:0];
        result_count <= result_count + 1;
        if (out_tdata[79:75] != 5'h0) begin
          $display("%0t: pad bits expected 0 actual %h", $realtime, out_tdata[79:75]);
          fail_count <= fail_count + 1;
        end
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            $display("%0t: mismatch expected st=%0d rd=%0d dv=%h y=%h yw=%b cc=%b%b%b",
                     $realtime, exp_r.status, exp_r.dest_index, exp_r.dest_value,
                     exp_r.y_out, exp_r.y_written, exp_r.set_cc, exp_r.cc_negative,
                     exp_r.cc_zero);
            $display("%0t:          actual   st=%0d rd=%0d dv=%h y=%h yw=%b cc=%b%b%b",
                     $realtime, got.status, got.dest_index, got.dest_value, got.y_out,
                     got.y_written, got.set_cc, got.cc_negative, got.cc_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_sparc_muldiv_emulation.sv @@
// Testbench top: drives instruction words into the multiply/divide block.
module tb_sparc_muldiv_emulation;
  import smd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 35;
  localparam int RANDOM_ITEMS = 1280;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  int           fail_count, pending, result_count;
  bit           idle_off = 1'b0;
  bit           hold_sink = 1'b0;
  int           mul_count = 0, div_count = 0, other_count = 0;

  always #10 clk = ~clk;

  sparc_muldiv_emulation DUT (.*);

  smd_checker u_checker (.*);

  // build a mul/div word: div, signed, cc select opcode bits
  function automatic logic [31:0] make_word(bit is_div, bit sgn, bit cc, bit imm);
    logic [31:0] w;
    w = $urandom;
    w = (w & ~SMD_OP_MASK) | SMD_OP_MATCH;
    w[21] = is_div; w[19] = sgn; w[23] = cc; w[13] = imm;
    return w;
  endfunction

  task automatic send(logic [31:0] iw, logic [31:0] a, logic [31:0] b, logic [31:0] y);
    int gap;
    if (!idle_off && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if ((iw & SMD_OP_MASK) != SMD_OP_MATCH) other_count++;
    else if (iw[21]) div_count++;
    else mul_count++;
    in_tvalid <= 1'b1;
    in_tdata <= {y, b, a, iw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stall bursts, or a long hold when asked
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_tready <= 1'b0;
        for (n = 0; n < 120; n++) @(negedge clk);
        hold_sink = 1'b0;
        out_tready <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [31:0] iw, a, b, y;
    int k, mode;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed corners
    send(make_word(0, 0, 1, 0), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send(make_word(0, 1, 1, 0), 32'h8000_0000, 32'h8000_0000, 32'h1234);
    send(make_word(0, 1, 1, 0), 32'h0, 32'h7FFF_FFFF, 32'h0);
    send(make_word(0, 0, 0, 1) | 32'h1FFF, 32'h5, 32'h0, 32'h0);
    send((make_word(0, 1, 1, 1) & ~32'h1FFF) | 32'h1000, 32'h3, 32'h0, 32'h0);
    send(make_word(1, 0, 1, 0), 32'hFFFF_FFFF, 32'h1, 32'h0);
    send(make_word(1, 0, 1, 0), 32'h5, 32'h0, 32'h0);
    send(make_word(1, 0, 0, 0), 32'h5, 32'h2, 32'h1);
    send(make_word(1, 0, 0, 0), 32'h5, 32'h2, 32'hFFFF_FFFF);
    send(make_word(1, 1, 1, 0), 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(make_word(1, 1, 1, 0), 32'hFFFF_FFF9, 32'h2, 32'hFFFF_FFFF);
    send(make_word(1, 1, 1, 0), 32'h7, 32'hFFFF_FFFE, 32'h0);
    send(make_word(1, 1, 0, 0), 32'h7, 32'h2, 32'hFFFF_FFFF);
    send(make_word(1, 1, 0, 0), 32'hFFFF_FFF9, 32'h2, 32'h0);
    send(make_word(1, 1, 1, 0), 32'h7, 32'h0, 32'h5);
    send(make_word(1, 1, 1, 1) & ~32'h1FFF, 32'h7, 32'h1, 32'h0);
    send(make_word(1, 0, 1, 0), 32'h0, 32'h3, 32'h0);
    send(32'h0, 32'h1, 32'h1, 32'h0);
    send(32'hFFFF_FFFF, 32'h1, 32'h1, 32'h0);
    send(make_word(0, 0, 0, 0) ^ 32'h0100_0000, 32'h2, 32'h3, 32'h0);
    in_tvalid <= 1'b0;
    // drain completely before the random part
    while (pending != 0) @(negedge clk);
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 300) hold_sink = 1'b1;
      if (k == RANDOM_ITEMS - 200) idle_off = 1'b1;
      mode = $urandom_range(0, 9);
      a = $urandom; b = $urandom;
      if ($urandom_range(0, 3) == 0) a = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 3) - 1;
      iw = make_word($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1));
      if (mode == 0) iw = $urandom;
      case ($urandom_range(0, 5))
        0: y = $urandom;
        1: y = 32'h0;
        2: y = 32'hFFFF_FFFF;
        default: y = {32{a[31]}};
      endcase
      if (iw[21] && !iw[19] && mode > 2) y = 32'h0;
      send(iw, a, b, y);
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    $display("Covered %0d multiplies, %0d divides, %0d other words; %0d results checked",
             mul_count, div_count, other_count, result_count);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

@@ sparc_muldiv_emulation.f @@
+incdir+sv
sv/smd_pkg.sv
sv/smd_front.sv
sv/smd_cell.sv
sv/sparc_muldiv_emulation.sv
tb/sv/smd_checker.sv
tb/sv/tb_sparc_muldiv_emulation.sv
